// File: rtl/core/uorb_pkg.sv
// Package with the shared constants, payload types and helpers of the receive ring buffer.
`timescale 1ns / 1ps

package uorb_pkg;

	// Buffer geometry and the per-request result limit.
	localparam int DEPTH   = 32;
	localparam int MAX_OUT = 32;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int DELIV_W = 7;

	// Operation codes of an input transaction.
	localparam logic OP_RX   = 1'b0;
	localparam logic OP_READ = 1'b1;

	// Input transaction payload.
	typedef struct packed {
		logic       op;
		logic [7:0] rx_byte;
		logic [3:0] error_bits;
		logic       rx_raised;
		logic       rx_fifo_empty;
		logic [7:0] read_len;
	} uorb_in_t;

	// Result transaction payload.
	typedef struct packed {
		logic               [7:0] rd_byte;
		logic                     byte_valid;
		logic                     last;
		logic [DELIV_W-1:0]       delivered;
	} uorb_out_t;

	// Control sequencer states.
	typedef enum logic [1:0] {
		S_IDLE,
		S_EMPTY,
		S_READ
	} uorb_state_t;

	// Advance a ring position with wrap at the buffer depth.
	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

// File: rtl/core/uorb_if.sv
// Valid/ready channel interfaces for input and result transactions.
`timescale 1ns / 1ps

interface uorb_in_if;
	logic                valid;
	logic                ready;
	uorb_pkg::uorb_in_t  data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uorb_out_if;
	logic                valid;
	logic                ready;
	uorb_pkg::uorb_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/uorb_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module uorb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/uorb_core.sv
// Top level of the overwrite-oldest receive ring buffer of a serial port.
`timescale 1ns / 1ps

// Receive ring buffer, 32 bytes deep, held in one synchronous RAM. A receive
// event (op 0) stores its byte only when no error flag is set, the receive
// interrupt is raised and the receive fifo is not empty; on a full buffer the
// oldest byte is overwritten. Receive events are taken back to back, one per
// cycle, while no read request is in progress. A read request (op 1) returns
// min(read_len, fill, 32) bytes oldest first, one per cycle while the result
// side takes them, with the final result marked by last and carrying the byte
// count in delivered; a request that finds nothing returns one empty result.
// The command side is held off while a read request streams out. The pace is
// set by the single RAM read port: the address of the next byte is presented
// as the current one is handed to the output register. No clearing pass is
// needed after reset.
module uart_rx_overwrite_ring_buffer_core (
	input  logic       clk,
	input  logic       arst_n,
	uorb_in_if.sink    cmd,
	uorb_out_if.source rsp
);

	import uorb_pkg::*;

	uorb_state_t        state_q;
	uorb_state_t        state_d;
	logic [PTR_W-1:0]   write_pos_q;
	logic [PTR_W-1:0]   read_pos_q;
	logic [PTR_W-1:0]   read_pos_d;
	logic [CNT_W-1:0]   fill_q;
	logic [CNT_W-1:0]   remain_q;
	logic [CNT_W-1:0]   total_q;
	logic               rdata_ok_q;
	logic               out_valid_q;
	uorb_out_t          out_q;
	logic [7:0]         rdata;

	logic               accept;
	logic               store;
	logic               req_rd;
	logic               full;
	logic               out_free;
	logic               pop;
	logic               last_pop;
	logic               emit_empty;
	logic [7:0]         n_wide;
	logic [CNT_W-1:0]   n_req;

	// Transaction decode.
	assign accept   = cmd.valid && cmd.ready;
	assign store    = accept && (cmd.data.op == OP_RX) && (cmd.data.error_bits == 4'd0)
			&& cmd.data.rx_raised && !cmd.data.rx_fifo_empty;
	assign req_rd   = accept && (cmd.data.op == OP_READ);
	assign full     = (fill_q == CNT_W'(DEPTH));
	assign out_free = !out_valid_q || rsp.ready;

	// Byte count of a read request, clamped to the fill and the result limit.
	assign n_wide = (cmd.data.read_len < 8'(fill_q)) ? cmd.data.read_len : 8'(fill_q);
	assign n_req  = (n_wide > 8'(MAX_OUT)) ? CNT_W'(MAX_OUT) : CNT_W'(n_wide);

	// A byte moves to the output register when the RAM data is current and the slot is free.
	assign pop        = (state_q == S_READ) && rdata_ok_q && out_free;
	assign last_pop   = pop && (remain_q == CNT_W'(1));
	assign emit_empty = (state_q == S_EMPTY) && out_free;

	// Read position: advances on an overwrite of a full buffer or on each byte taken.
	always_comb begin
		read_pos_d = read_pos_q;
		if ((store && full) || pop) begin
			read_pos_d = next_pos(read_pos_q);
		end
	end

	// Byte storage; the read address follows the next read position.
	uorb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (store),
		.waddr (write_pos_q),
		.wdata (cmd.data.rx_byte),
		.raddr (read_pos_d),
		.rdata (rdata)
	);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_rd) begin
					state_d = (n_req == '0) ? S_EMPTY : S_READ;
				end
			end
			S_EMPTY: begin
				if (emit_empty) begin
					state_d = S_IDLE;
				end
			end
			S_READ: begin
				if (last_pop) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Output logic of the sequencer.
	always_comb begin
		case (state_q)
			S_IDLE:  cmd.ready = 1'b1;
			default: cmd.ready = 1'b0;
		endcase
	end

	// Control state, pointers and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			write_pos_q <= '0;
			read_pos_q  <= '0;
			fill_q      <= '0;
			remain_q    <= '0;
			total_q     <= '0;
			rdata_ok_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			read_pos_q <= read_pos_d;
			// RAM data is stale in the cycle after a write.
			rdata_ok_q <= !store;
			if (store) begin
				write_pos_q <= next_pos(write_pos_q);
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (pop) begin
				fill_q <= fill_q - 1'b1;
			end
			if (req_rd) begin
				remain_q <= n_req;
				total_q  <= n_req;
			end else if (pop) begin
				remain_q <= remain_q - 1'b1;
			end
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop || emit_empty) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (pop) begin
			out_q.rd_byte    <= rdata;
			out_q.byte_valid <= 1'b1;
			out_q.last       <= last_pop;
			out_q.delivered  <= last_pop ? DELIV_W'(total_q) : '0;
		end else if (emit_empty) begin
			out_q.rd_byte    <= '0;
			out_q.byte_valid <= 1'b0;
			out_q.last       <= 1'b1;
			out_q.delivered  <= '0;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;

endmodule
